>>> rtl/assert_macros.svh
// Assertion macros for the RTL files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tsa_pkg.sv
// Package: cell codes, widths and lane types for the automaton row step.
package tsa_pkg;

	localparam int ROW_W     = 64;
	localparam int CELL_W    = 2;
	localparam int MAX_CELLS = ROW_W / CELL_W;

	localparam logic [CELL_W-1:0] CELL_DEAD  = 2'd0;
	localparam logic [CELL_W-1:0] CELL_DYING = 2'd1;
	localparam logic [CELL_W-1:0] CELL_ALIVE = 2'd2;

	// alive-neighbour count that turns a dead cell alive
	localparam logic [3:0] ALIVE_NEED = 4'd2;

	// one lane's view: its eight neighbours' alive bits and its own code
	typedef struct packed {
		logic [7:0]        alive;
		logic [CELL_W-1:0] code;
	} nbr_t;

	function automatic logic is_alive(input logic [CELL_W-1:0] code);
		return code == CELL_ALIVE;
	endfunction

endpackage

>>> rtl/tsa_chan_if.sv
// Channel interfaces: input rows and result rows, valid/ready handshake.
interface tsa_in_if;
	logic                     valid;
	logic                     ready;
	logic [tsa_pkg::ROW_W-1:0] row_cells;
	logic                     last_row;

	modport source (output valid, output row_cells, output last_row, input ready);
	modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface tsa_out_if;
	logic                     valid;
	logic                     ready;
	logic [tsa_pkg::ROW_W-1:0] next_row;
	logic                     last;

	modport source (output valid, output next_row, output last, input ready);
	modport sink   (input valid, input next_row, input last, output ready);
endinterface

>>> rtl/tsa_lane.sv
// One cell lane: neighbour count and the three-state rule.
module tsa_lane (
	input  tsa_pkg::nbr_t                nbr,
	output logic [tsa_pkg::CELL_W-1:0]   next_code
);

	logic [3:0] count;

	// count alive neighbours
	assign count = 4'($countones(nbr.alive));

	// alive -> dying -> dead; dead (and code three) may be born
	always_comb begin
		case (nbr.code)
			tsa_pkg::CELL_ALIVE: next_code = tsa_pkg::CELL_DYING;
			tsa_pkg::CELL_DYING: next_code = tsa_pkg::CELL_DEAD;
			default: next_code = (count == tsa_pkg::ALIVE_NEED) ?
				tsa_pkg::CELL_ALIVE : tsa_pkg::CELL_DEAD;
		endcase
	end

endmodule

>>> rtl/tsa_row_gen.sv
// Row of cell lanes over three rows; merges lane codes into one result row.
module tsa_row_gen #(
	parameter int COLS = 32
) (
	input  logic [tsa_pkg::ROW_W-1:0] above,
	input  logic [tsa_pkg::ROW_W-1:0] center,
	input  logic [tsa_pkg::ROW_W-1:0] below,
	output logic [tsa_pkg::ROW_W-1:0] next_row
);

	localparam int CW = tsa_pkg::CELL_W;

	for (genvar c = 0; c < tsa_pkg::MAX_CELLS; c++) begin : g_cell
		if (c < COLS) begin : g_used
			// border columns see no neighbour beyond the edge
			localparam bit HAS_L = (c > 0);
			localparam bit HAS_R = (c + 1 < COLS);
			localparam int LI    = HAS_L ? c - 1 : c;
			localparam int RI    = HAS_R ? c + 1 : c;

			tsa_pkg::nbr_t nbr;

			always_comb begin
				nbr.code     = center[CW*c +: CW];
				nbr.alive[0] = HAS_L && tsa_pkg::is_alive(above[CW*LI +: CW]);
				nbr.alive[1] = tsa_pkg::is_alive(above[CW*c +: CW]);
				nbr.alive[2] = HAS_R && tsa_pkg::is_alive(above[CW*RI +: CW]);
				nbr.alive[3] = HAS_L && tsa_pkg::is_alive(center[CW*LI +: CW]);
				nbr.alive[4] = HAS_R && tsa_pkg::is_alive(center[CW*RI +: CW]);
				nbr.alive[5] = HAS_L && tsa_pkg::is_alive(below[CW*LI +: CW]);
				nbr.alive[6] = tsa_pkg::is_alive(below[CW*c +: CW]);
				nbr.alive[7] = HAS_R && tsa_pkg::is_alive(below[CW*RI +: CW]);
			end

			tsa_lane u_lane (
				.nbr       (nbr),
				.next_code (next_row[CW*c +: CW])
			);
		end else begin : g_unused
			// columns beyond the grid read as zero
			assign next_row[CW*c +: CW] = tsa_pkg::CELL_DEAD;
		end
	end

endmodule

>>> rtl/three_state_automaton_row_step.sv
// Top level: one grid row per item in, next-generation rows out.
// A result row passes through the hold stage and then the out register.
// Throughput: one item per cycle while the output does not stall; a bottom row that follows a held row makes two
// result rows and holds the input off until its first result row moves on, set by the single lane array.
// Reset (arst_n low, asynchronous): held rows cleared to dead, no item in flight.
`include "assert_macros.svh"

module three_state_automaton_row_step #(
	parameter int GRID_COLUMNS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tsa_in_if.sink    in_row,
	tsa_out_if.source out_row
);

	localparam int W = tsa_pkg::ROW_W;

	// held rows
	logic [W-1:0] upper_q, middle_q;
	logic         held_q;

	// hold stage: one accepted item with up to two jobs
	logic [W-1:0] up_s1, mid_s1, row_s1;
	logic         held_s1, last_s1, phase_s1, v_s1;

	// output register
	logic [W-1:0] next_row_q;
	logic         last_q, out_v_q;

	logic         in_acc, out_adv, job0, final_job;
	logic [W-1:0] sel_above, sel_center, sel_below, gen_row;

	assign in_acc    = in_row.valid && in_row.ready;
	assign out_adv   = !out_v_q || out_row.ready;
	assign job0      = held_s1 && !phase_s1;
	assign final_job = !(job0 && last_s1);

	assign in_row.ready = !v_s1 || (out_adv && final_job);

	// held-row state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= '0;
			middle_q <= '0;
			held_q   <= 1'b0;
		end else if (in_acc) begin
			if (in_row.last_row) begin
				upper_q  <= '0;
				middle_q <= '0;
				held_q   <= 1'b0;
			end else begin
				upper_q  <= held_q ? middle_q : '0;
				middle_q <= in_row.row_cells;
				held_q   <= 1'b1;
			end
		end
	end

	// hold stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1     <= held_q || in_row.last_row;
			phase_s1 <= 1'b0;
		end else if (v_s1 && out_adv) begin
			if (final_job) begin
				v_s1 <= 1'b0;
			end else begin
				phase_s1 <= 1'b1;
			end
		end
	end

	// hold stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			up_s1   <= upper_q;
			mid_s1  <= middle_q;
			row_s1  <= in_row.row_cells;
			held_s1 <= held_q;
			last_s1 <= in_row.last_row;
		end
	end

	// job select: row above the new one, or the bottom row itself
	always_comb begin
		if (job0) begin
			sel_above  = up_s1;
			sel_center = mid_s1;
			sel_below  = row_s1;
		end else begin
			sel_above  = held_s1 ? mid_s1 : '0;
			sel_center = row_s1;
			sel_below  = '0;
		end
	end

	tsa_row_gen #(
		.COLS (GRID_COLUMNS)
	) u_row_gen (
		.above    (sel_above),
		.center   (sel_center),
		.below    (sel_below),
		.next_row (gen_row)
	);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_adv) begin
			out_v_q <= v_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			next_row_q <= gen_row;
			last_q     <= !job0;
		end
	end

	assign out_row.valid    = out_v_q;
	assign out_row.next_row = next_row_q;
	assign out_row.last     = last_q;

	`ASSERT_SAME(a_stage_has_work, v_s1, held_s1 || last_s1, "hold stage without a job")
	`ASSERT_SAME(a_phase_double, v_s1 && phase_s1, held_s1 && last_s1, "second job on single item")
	`ASSERT_NEXT(a_second_job, v_s1 && out_adv && !final_job, v_s1 && phase_s1, "second job lost")
	`ASSERT_NEXT(a_clear_after_last, in_acc && in_row.last_row, !held_q, "rows held after bottom row")

endmodule

>>> tb/tb_three_state_automaton_row_step.sv
`timescale 1ns / 100ps
// Testbench for the Brian's Brain row step: directed rows, random grids, row-level predictor.
module tb_three_state_automaton_row_step;

	localparam int COLS           = 32;
	localparam int STALL_LIMIT    = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int ROWS_PER_PHASE = 170;
	localparam int SETTLE_CYCLES  = 8;
	localparam int SHOWN_ERRORS   = 10;
	localparam int N_DIRECTED     = 22;

	typedef struct packed {
		logic [tsa_pkg::ROW_W-1:0] next_row;
		logic                      last;
	} gen_row_t;

	// directed row; when hand_checked is set, want is the single result (last = 1)
	typedef struct packed {
		logic [tsa_pkg::ROW_W-1:0] row;
		logic                      last;
		logic                      hand_checked;
		logic [tsa_pkg::ROW_W-1:0] want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// one-row grids, result read off by hand
		'{64'h0, 1'b1, 1'b1, 64'h0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 64'h5555_5555_5555_5555},
		'{64'h5555_5555_5555_5555, 1'b1, 1'b1, 64'h0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0},
		'{64'h22, 1'b1, 1'b1, 64'h19},
		'{64'h8000_0000_0000_0008, 1'b1, 1'b1, 64'h4000_0000_0000_0004},
		'{64'h2000_0000_0000_0002, 1'b1, 1'b1, 64'h1000_0000_0000_0001},
		'{64'h23, 1'b1, 1'b1, 64'h10},
		// vertical pair around a dead row
		'{64'h800, 1'b0, 1'b0, 64'h0},
		'{64'h0, 1'b0, 1'b0, 64'h0},
		'{64'h800, 1'b1, 1'b0, 64'h0},
		// two-row grid
		'{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
		'{64'h0, 1'b1, 1'b0, 64'h0},
		// top and bottom border
		'{64'h22, 1'b0, 1'b0, 64'h0},
		'{64'h0, 1'b0, 1'b0, 64'h0},
		'{64'h8000_0000_0000_0008, 1'b1, 1'b0, 64'h0},
		// mixed codes
		'{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0},
		'{64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 64'h0},
		'{64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 64'h0},
		'{64'h5A5A_A5A5_2222_8888, 1'b1, 1'b0, 64'h0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
		'{64'h0, 1'b1, 1'b0, 64'h0}
	};

	logic clk;
	logic arst_n;

	tsa_in_if  in_ch();
	tsa_out_if out_ch();

	three_state_automaton_row_step #(
		.GRID_COLUMNS(COLS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_row (in_ch),
		.out_row(out_ch)
	);

	// predictor state: two held rows and how many are held
	logic [tsa_pkg::ROW_W-1:0] above_row;
	logic [tsa_pkg::ROW_W-1:0] pending_row;
	int unsigned               rows_held;
	gen_row_t                  next_gen_q[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int          hold_left;
	int          mismatches;
	int          rows_sent;
	int          grids_sent;
	int          results_seen;
	int          input_stalls;
	int          quiet_cycles;

	// 20 ns clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// alive bit of cell c, cells off the grid are not alive
	function automatic int alive_at(input logic [tsa_pkg::ROW_W-1:0] row, input int c);
		if (c < 0 || c >= COLS)
			return 0;
		return (row[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] == tsa_pkg::CELL_ALIVE) ? 1 : 0;
	endfunction

	// next generation of row, given its neighbours above and below
	function automatic logic [tsa_pkg::ROW_W-1:0] evolve_row(
			input logic [tsa_pkg::ROW_W-1:0] above,
			input logic [tsa_pkg::ROW_W-1:0] row, input logic [tsa_pkg::ROW_W-1:0] below);
		logic [tsa_pkg::ROW_W-1:0]  nxt;
		logic [tsa_pkg::CELL_W-1:0] code;
		int                         n;
		nxt = '0;
		for (int c = 0; c < COLS; c++) begin
			n = 0;
			for (int d = -1; d <= 1; d++) begin
				n += alive_at(above, c + d) + alive_at(below, c + d);
				if (d != 0)
					n += alive_at(row, c + d);
			end
			code = row[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W];
			if (code == tsa_pkg::CELL_ALIVE)
				nxt[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] = tsa_pkg::CELL_DYING;
			else if (code == tsa_pkg::CELL_DYING)
				nxt[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] = tsa_pkg::CELL_DEAD;
			else if (n == tsa_pkg::ALIVE_NEED)
				nxt[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] = tsa_pkg::CELL_ALIVE;
		end
		return nxt;
	endfunction

	// advance the predictor by one accepted row and queue its results
	function automatic void predict_row(input logic [tsa_pkg::ROW_W-1:0] row,
			input logic last, input logic hand_checked,
			input logic [tsa_pkg::ROW_W-1:0] want);
		gen_row_t g;
		if (rows_held != 0) begin
			g.next_row = evolve_row(above_row, pending_row, row);
			g.last     = 1'b0;
			next_gen_q.push_back(g);
			above_row = pending_row;
		end else begin
			above_row = '0;
		end
		pending_row = row;
		rows_held   = (rows_held < 2) ? rows_held + 1 : 2;
		if (last) begin
			g.next_row = hand_checked ? want : evolve_row(above_row, pending_row, '0);
			g.last     = 1'b1;
			next_gen_q.push_back(g);
			above_row   = '0;
			pending_row = '0;
			rows_held   = 0;
		end
	endfunction

	// random row: uniform codes, sparse alive cells, or dense live cells
	function automatic logic [tsa_pkg::ROW_W-1:0] random_row();
		logic [tsa_pkg::ROW_W-1:0] r;
		int unsigned               kind;
		int unsigned               pick;
		kind = $urandom_range(9);
		r    = {$urandom, $urandom};
		if (kind < 4)
			return r;
		for (int c = 0; c < COLS; c++) begin
			pick = $urandom_range(11);
			if (kind < 7)
				r[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] =
					(pick < 2) ? tsa_pkg::CELL_ALIVE : tsa_pkg::CELL_DEAD;
			else if (pick < 6)
				r[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] = tsa_pkg::CELL_ALIVE;
			else if (pick < 9)
				r[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] = tsa_pkg::CELL_DYING;
			else
				r[tsa_pkg::CELL_W*c +: tsa_pkg::CELL_W] = tsa_pkg::CELL_DEAD;
		end
		return r;
	endfunction

	function automatic void note_mismatch(input string what,
			input logic [tsa_pkg::ROW_W-1:0] want, input logic [tsa_pkg::ROW_W-1:0] got);
		mismatches++;
		if (mismatches <= SHOWN_ERRORS)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endfunction

	// offer one row from a falling edge, return at the falling edge after it is taken
	task automatic send_row(input logic [tsa_pkg::ROW_W-1:0] row, input logic last,
			input logic hand_checked, input logic [tsa_pkg::ROW_W-1:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.row_cells <= row;
		in_ch.last_row  <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_row(row, last, hand_checked, want);
		rows_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait until every queued result has come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (next_gen_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random grids under one idling setting, optional long receiver hold-off
	task automatic run_grids(input int unsigned send_pct, input int unsigned recv_pct,
			input int hold);
		int sent;
		int height;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		hold_left     = hold;
		sent          = 0;
		while (sent < ROWS_PER_PHASE) begin
			height = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
			for (int r = 0; r < height; r++)
				send_row(random_row(), r == height - 1, 1'b0, '0);
			sent += height;
			grids_sent++;
		end
	endtask

	// receiver: long hold-off when asked, else random back-pressure
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result check against the oldest queued row
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (next_gen_q.size() == 0) begin
				note_mismatch("unexpected result", '0, out_ch.next_row);
			end else begin
				if (out_ch.next_row !== next_gen_q[0].next_row)
					note_mismatch("next_row", next_gen_q[0].next_row, out_ch.next_row);
				if (out_ch.last !== next_gen_q[0].last)
					note_mismatch("last", next_gen_q[0].last, out_ch.last);
				void'(next_gen_q.pop_front());
			end
		end
	end

	// watchdog on cycles where no item moves on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && in_ch.valid && !in_ch.ready)
			input_stalls++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, next_gen_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.row_cells = '0;
		in_ch.last_row  = 1'b0;
		out_ch.ready    = 1'b0;
		above_row       = '0;
		pending_row     = '0;
		rows_held       = 0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_left       = 0;
		mismatches      = 0;
		rows_sent       = 0;
		grids_sent      = 0;
		results_seen    = 0;
		input_stalls    = 0;
		quiet_cycles    = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_row(DIRECTED[i].row, DIRECTED[i].last, DIRECTED[i].hand_checked,
				DIRECTED[i].want);
			if (DIRECTED[i].last)
				grids_sent++;
		end
		drain_results();

		// random grids: sender idles less, then receiver idles less, then no idling after a long receiver hold-off
		run_grids(20, 64, 0);
		drain_results();
		run_grids(64, 20, 0);
		drain_results();
		run_grids(0, 0, HOLD_CYCLES);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (next_gen_q.size() != 0) begin
			mismatches += next_gen_q.size();
			$display("%0d expected results never arrived", next_gen_q.size());
		end
		$display("covered %0d rows in %0d grids, %0d result rows checked",
			rows_sent, grids_sent, results_seen);
		$display("input held off on %0d cycles, %0d mismatches", input_stalls, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/tsa_pkg.sv
rtl/tsa_chan_if.sv
rtl/tsa_lane.sv
rtl/tsa_row_gen.sv
rtl/three_state_automaton_row_step.sv
tb/tb_three_state_automaton_row_step.sv
